[hdl/rs485_frame_parser_crc8_defines.svh]
// Assertion helpers for the frame parser.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef RS485_FRAME_PARSER_CRC8_DEFINES_SVH
`define RS485_FRAME_PARSER_CRC8_DEFINES_SVH

// Same-cycle implication
`define RFPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define RFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rfpc_pkg.sv]
package rfpc_pkg;

  // Sizes
  localparam int MAX_PAYLOAD = 32;
  localparam int DATA_W      = 8;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 6;
  localparam int PIDX_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_EXT_W   = DATA_W + 1;

  localparam logic [DATA_W-1:0] HEAD_RESET = 8'hf7;
  localparam logic [DATA_W-1:0] CRC_POLY   = 8'h07;
  localparam logic [DATA_W-1:0] MIN_BODY   = 8'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic ERR_LEN = 1'b0;
  localparam logic ERR_CRC = 1'b1;

  // Frame parsing phase
  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_ADDR    = 7'b0000010,
    PH_LEN     = 7'b0000100,
    PH_STATE   = 7'b0001000,
    PH_FUNC    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CRC     = 7'b1000000
  } phase_t;

  // Input side vs. payload burst
  typedef enum logic [1:0] {
    CTL_RUN  = 2'b01,
    CTL_EMIT = 2'b10
  } ctl_t;

  // One byte through the CRC-8, MSB first
  function automatic logic [DATA_W-1:0] crc8_step(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < DATA_W; i++) begin
      if (c[DATA_W-1]) begin
        c = {c[DATA_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[DATA_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/rs485_frame_parser_crc8.sv]
// Results of an accepted byte appear in the output register in the next cycle.
// Throughput: one byte per cycle, limited by the single output register and paused in a burst.
// A good frame's CRC byte loads the header, then one payload byte per free output
// cycle from the payload RAM; input stalls for the whole burst.
// Reset (rst_n low, synchronous): hunting, head byte 0xf7, output empty.
// The payload RAM is not cleared; every byte read was written by the same frame.
`include "rs485_frame_parser_crc8_defines.svh"

module rs485_frame_parser_crc8 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rfpc_pkg::DATA_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rfpc_pkg::DATA_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rfpc_pkg::KIND_W-1:0]    out_kind,
  output logic                           out_error_code,
  output logic [rfpc_pkg::DATA_W-1:0]    out_slave_addr,
  output logic [rfpc_pkg::DATA_W-1:0]    out_frame_state,
  output logic [rfpc_pkg::DATA_W-1:0]    out_function_code,
  output logic [rfpc_pkg::COUNT_W-1:0]   out_payload_count,
  output logic [rfpc_pkg::DATA_W-1:0]    out_data_byte,
  output logic                           out_last
);
  import rfpc_pkg::*;

  // Control state
  ctl_t                ctl_r, ctl_nxt;
  phase_t              phase_r, phase_nxt;
  logic [DATA_W-1:0]   head_r;
  logic                out_valid_r, out_valid_nxt;

  // Frame fields
  logic [DATA_W-1:0]   crc_r, crc_nxt;
  logic [DATA_W-1:0]   addr_r, addr_nxt;
  logic [DATA_W-1:0]   len_r, len_nxt;
  logic [DATA_W-1:0]   state_r, state_nxt;
  logic [DATA_W-1:0]   func_r, func_nxt;
  logic [COUNT_W-1:0]  pidx_r, pidx_nxt;
  logic [COUNT_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic [COUNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;

  // Output register
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic                err_r, err_nxt;
  logic [DATA_W-1:0]   oaddr_r, oaddr_nxt;
  logic [DATA_W-1:0]   ostate_r, ostate_nxt;
  logic [DATA_W-1:0]   ofunc_r, ofunc_nxt;
  logic [COUNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [DATA_W-1:0]   odata_r, odata_nxt;
  logic                olast_r, olast_nxt;

  // Payload RAM
  logic [DATA_W-1:0]   mem [MAX_PAYLOAD];
  logic [DATA_W-1:0]   mem_q;
  logic                mem_we, mem_re;
  logic [PIDX_W-1:0]   mem_wa, mem_ra;

  // Helpers
  logic                out_free;
  logic                in_acc;
  logic                emit_last;
  logic [DATA_W-1:0]   crc_in;
  logic [LEN_EXT_W-1:0] len_m2;
  logic [LEN_EXT_W-1:0] pidx_p3;
  logic [COUNT_W-1:0]  frame_cnt;
  logic                len_bad;
  logic [COUNT_W-1:0]  pidx_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((ctl_r == CTL_RUN) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign emit_last = (emit_idx_r == emit_cnt_r - COUNT_W'(1));
  assign crc_in    = (phase_r == PH_LEN) ? '0 : crc_r;
  assign pidx_inc  = pidx_r + COUNT_W'(1);
  assign pidx_p3   = LEN_EXT_W'(pidx_inc) + LEN_EXT_W'(2);
  assign len_m2    = {1'b0, len_r} - LEN_EXT_W'(MIN_BODY);
  assign len_bad   = (in_rx_byte < MIN_BODY) ||
                     (LEN_EXT_W'(in_rx_byte) > LEN_EXT_W'(MAX_PAYLOAD + 2));

  // Payload count of the held frame, clamped as the buffer allows
  always_comb begin
    if (len_r < MIN_BODY) begin
      frame_cnt = '0;
    end else if (len_m2 > LEN_EXT_W'(MAX_PAYLOAD)) begin
      frame_cnt = COUNT_W'(MAX_PAYLOAD);
    end else begin
      frame_cnt = len_m2[COUNT_W-1:0];
    end
  end

  // Next-state logic: byte parsing and payload burst
  always_comb begin
    ctl_nxt       = ctl_r;
    phase_nxt     = phase_r;
    crc_nxt       = crc_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    state_nxt     = state_r;
    func_nxt      = func_r;
    pidx_nxt      = pidx_r;
    emit_idx_nxt  = emit_idx_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    oaddr_nxt     = oaddr_r;
    ostate_nxt    = ostate_r;
    ofunc_nxt     = ofunc_r;
    ocnt_nxt      = ocnt_r;
    odata_nxt     = odata_r;
    olast_nxt     = olast_r;
    mem_we        = 1'b0;
    mem_wa        = pidx_r[PIDX_W-1:0];
    mem_re        = 1'b0;
    mem_ra        = '0;

    if (ctl_r == CTL_EMIT) begin
      // One buffered payload byte per free output slot
      if (out_free) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_DATA;
        err_nxt       = 1'b0;
        oaddr_nxt     = '0;
        ostate_nxt    = '0;
        ofunc_nxt     = '0;
        ocnt_nxt      = '0;
        odata_nxt     = mem_q;
        olast_nxt     = emit_last;
        emit_idx_nxt  = emit_idx_r + COUNT_W'(1);
        mem_re        = 1'b1;
        mem_ra        = emit_idx_nxt[PIDX_W-1:0];
        if (emit_last) begin
          ctl_nxt = CTL_RUN;
        end
      end
    end else if (in_acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == head_r) begin
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_nxt  = in_rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (len_bad) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_ERR;
            err_nxt       = ERR_LEN;
            oaddr_nxt     = '0;
            ostate_nxt    = '0;
            ofunc_nxt     = '0;
            ocnt_nxt      = '0;
            odata_nxt     = '0;
            olast_nxt     = 1'b1;
            // Rescan the held address, then this byte
            if (addr_r == head_r) begin
              addr_nxt  = in_rx_byte;
              phase_nxt = PH_LEN;
            end else if (in_rx_byte == head_r) begin
              phase_nxt = PH_ADDR;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end else begin
            len_nxt   = in_rx_byte;
            crc_nxt   = crc8_step(crc_in, in_rx_byte);
            pidx_nxt  = '0;
            phase_nxt = PH_STATE;
          end
        end
        PH_STATE: begin
          state_nxt = in_rx_byte;
          crc_nxt   = crc8_step(crc_in, in_rx_byte);
          phase_nxt = PH_FUNC;
        end
        PH_FUNC: begin
          func_nxt  = in_rx_byte;
          crc_nxt   = crc8_step(crc_in, in_rx_byte);
          phase_nxt = (len_r > MIN_BODY) ? PH_PAYLOAD : PH_CRC;
        end
        PH_PAYLOAD: begin
          mem_we   = (pidx_r < COUNT_W'(MAX_PAYLOAD));
          pidx_nxt = pidx_inc;
          crc_nxt  = crc8_step(crc_in, in_rx_byte);
          // Last payload byte once the new count plus two reaches the length
          if (pidx_p3 >= {1'b0, len_r}) begin
            phase_nxt = PH_CRC;
          end
        end
        default: begin
          // CRC byte: header plus burst, or error report
          phase_nxt     = PH_HUNT;
          out_valid_nxt = 1'b1;
          odata_nxt     = '0;
          if (in_rx_byte != crc_r) begin
            kind_nxt   = KIND_ERR;
            err_nxt    = ERR_CRC;
            oaddr_nxt  = '0;
            ostate_nxt = '0;
            ofunc_nxt  = '0;
            ocnt_nxt   = '0;
            olast_nxt  = 1'b1;
          end else begin
            kind_nxt     = KIND_HDR;
            err_nxt      = 1'b0;
            oaddr_nxt    = addr_r;
            ostate_nxt   = state_r;
            ofunc_nxt    = func_r;
            ocnt_nxt     = frame_cnt;
            olast_nxt    = (frame_cnt == '0);
            emit_cnt_nxt = frame_cnt;
            emit_idx_nxt = '0;
            mem_re       = 1'b1;
            mem_ra       = '0;
            if (frame_cnt != '0) begin
              ctl_nxt = CTL_EMIT;
            end
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= CTL_RUN;
      phase_r     <= PH_HUNT;
      head_r      <= HEAD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        head_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    state_r    <= state_nxt;
    func_r     <= func_nxt;
    pidx_r     <= pidx_nxt;
    emit_idx_r <= emit_idx_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    kind_r     <= kind_nxt;
    err_r      <= err_nxt;
    oaddr_r    <= oaddr_nxt;
    ostate_r   <= ostate_nxt;
    ofunc_r    <= ofunc_nxt;
    ocnt_r     <= ocnt_nxt;
    odata_r    <= odata_nxt;
    olast_r    <= olast_nxt;
  end

  // Payload RAM, registered read; writes only while parsing, reads at a good CRC byte and in the burst
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // Outputs
  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_error_code    = err_r;
  assign out_slave_addr    = oaddr_r;
  assign out_frame_state   = ostate_r;
  assign out_function_code = ofunc_r;
  assign out_payload_count = ocnt_r;
  assign out_data_byte     = odata_r;
  assign out_last          = olast_r;

  // Checks
  `RFPC_ASSERT_NOW(a_stall_in_burst, ctl_r == CTL_EMIT, in_stall, "input taken during burst")
  `RFPC_ASSERT_NOW(a_no_write_in_burst, mem_we, ctl_r == CTL_RUN, "RAM write during burst")
  `RFPC_ASSERT_NOW(a_emit_idx_range, ctl_r == CTL_EMIT, emit_idx_r < emit_cnt_r, "burst index overrun")
  `RFPC_ASSERT_NEXT(a_burst_ends, (ctl_r == CTL_EMIT) && out_free && emit_last, (ctl_r == CTL_RUN) && out_last, "burst did not end on last")

endmodule

[bench/tb_rs485_frame_parser_crc8.sv]
module tb_rs485_frame_parser_crc8;
  import rfpc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 240;
  localparam int SETTLE       = 4;
  localparam int MAX_PRINTS   = 40;

  // One result item as the block should emit it
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic               err;
    logic [DATA_W-1:0]  addr;
    logic [DATA_W-1:0]  state;
    logic [DATA_W-1:0]  func;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  data;
    logic               last;
  } frame_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [DATA_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    out_kind;
  logic                 out_error_code;
  logic [DATA_W-1:0]    out_slave_addr;
  logic [DATA_W-1:0]    out_frame_state;
  logic [DATA_W-1:0]    out_function_code;
  logic [COUNT_W-1:0]   out_payload_count;
  logic [DATA_W-1:0]    out_data_byte;
  logic                 out_last;

  // Deframer mirror state
  logic [DATA_W-1:0]    head_cfg = HEAD_RESET;
  phase_t               ph = PH_HUNT;
  logic [DATA_W-1:0]    run_crc = '0;
  logic [DATA_W-1:0]    held_addr = '0;
  logic [DATA_W-1:0]    frame_len = '0;
  logic [DATA_W-1:0]    held_state = '0;
  logic [DATA_W-1:0]    held_func = '0;
  logic [COUNT_W-1:0]   pay_idx = '0;
  logic [DATA_W-1:0]    pay_store [MAX_PAYLOAD];

  frame_rec_t           frame_out_q[$];

  // Run bookkeeping
  int                   errors = 0;
  int                   items_sent = 0;
  int                   heads_written = 0;
  int                   n_hdr = 0;
  int                   n_data = 0;
  int                   n_err = 0;
  int                   cycle_count = 0;
  int                   hold_req = 0;
  bit                   no_idle = 1'b0;

  rs485_frame_parser_crc8 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_error_code    (out_error_code),
    .out_slave_addr    (out_slave_addr),
    .out_frame_state   (out_frame_state),
    .out_function_code (out_function_code),
    .out_payload_count (out_payload_count),
    .out_data_byte     (out_data_byte),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-8, poly 0x07, MSB first
  function automatic logic [DATA_W-1:0] crc07_byte(input logic [DATA_W-1:0] acc,
                                                   input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    c = acc ^ b;
    repeat (DATA_W) c = c[DATA_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void push_rec(input logic [KIND_W-1:0] kind, input logic err,
                                   input logic [DATA_W-1:0] addr,
                                   input logic [DATA_W-1:0] st,
                                   input logic [DATA_W-1:0] fn,
                                   input logic [COUNT_W-1:0] cnt,
                                   input logic [DATA_W-1:0] data, input logic last);
    frame_rec_t r;
    r.kind  = kind;
    r.err   = err;
    r.addr  = addr;
    r.state = st;
    r.func  = fn;
    r.count = cnt;
    r.data  = data;
    r.last  = last;
    frame_out_q.push_back(r);
  endfunction

  // Head search and address capture
  function automatic void scan_rx(input logic [DATA_W-1:0] b);
    if (ph == PH_HUNT) begin
      if (b == head_cfg) ph = PH_ADDR;
    end else if (ph == PH_ADDR) begin
      held_addr = b;
      ph = PH_LEN;
    end
  endfunction

  // Advance the mirror by one received byte, queue what it should produce
  function automatic void parse_rx_byte(input logic [DATA_W-1:0] b);
    logic [COUNT_W-1:0] cnt;
    case (ph)
      PH_HUNT, PH_ADDR: scan_rx(b);
      PH_LEN: begin
        if (b < MIN_BODY || b > MAX_PAYLOAD + 2) begin
          // drop the head, rescan address then length
          push_rec(KIND_ERR, ERR_LEN, '0, '0, '0, '0, '0, 1'b1);
          ph = PH_HUNT;
          scan_rx(held_addr);
          scan_rx(b);
        end else begin
          frame_len = b;
          run_crc = crc07_byte('0, b);
          pay_idx = '0;
          ph = PH_STATE;
        end
      end
      PH_STATE: begin
        held_state = b;
        run_crc = crc07_byte(run_crc, b);
        ph = PH_FUNC;
      end
      PH_FUNC: begin
        held_func = b;
        run_crc = crc07_byte(run_crc, b);
        ph = (frame_len > MIN_BODY) ? PH_PAYLOAD : PH_CRC;
      end
      PH_PAYLOAD: begin
        if (pay_idx < MAX_PAYLOAD) pay_store[pay_idx[PIDX_W-1:0]] = b;
        pay_idx = pay_idx + 1'b1;
        run_crc = crc07_byte(run_crc, b);
        if (pay_idx + 2 >= frame_len) ph = PH_CRC;
      end
      default: begin
        ph = PH_HUNT;
        if (b != run_crc) begin
          push_rec(KIND_ERR, ERR_CRC, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          cnt = COUNT_W'(frame_len - MIN_BODY);
          push_rec(KIND_HDR, 1'b0, held_addr, held_state, held_func, cnt, '0, cnt == 0);
          for (int i = 0; i < cnt; i++) begin
            push_rec(KIND_DATA, 1'b0, '0, '0, '0, '0, pay_store[i], i == cnt - 1);
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Offer one item, hold it until taken, then update the mirror
  task automatic send_byte(input logic [DATA_W-1:0] b);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 20) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_rx_byte(b);
    items_sent++;
  endtask

  // Length byte onward; head and address already sent
  task automatic continue_frame(input logic [DATA_W-1:0] len, input logic [DATA_W-1:0] st,
                                input logic [DATA_W-1:0] fn, input bit corrupt);
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] b;
    c = crc07_byte('0, len);
    send_byte(len);
    send_byte(st);
    c = crc07_byte(c, st);
    send_byte(fn);
    c = crc07_byte(c, fn);
    for (int i = 0; i < len - 2; i++) begin
      b = DATA_W'($urandom_range(255));
      send_byte(b);
      c = crc07_byte(c, b);
    end
    if (corrupt) c = c ^ (8'h01 << $urandom_range(7));
    send_byte(c);
  endtask

  task automatic send_frame(input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] len,
                            input logic [DATA_W-1:0] st, input logic [DATA_W-1:0] fn,
                            input bit corrupt);
    send_byte(head_cfg);
    send_byte(addr);
    continue_frame(len, st, fn, corrupt);
  endtask

  // Mostly short bodies, some full-size ones
  task automatic random_frame(input bit corrupt);
    int pick;
    logic [DATA_W-1:0] len;
    pick = $urandom_range(99);
    if (pick < 55) len = DATA_W'($urandom_range(2, 6));
    else if (pick < 80) len = DATA_W'($urandom_range(7, MAX_PAYLOAD + 1));
    else len = DATA_W'(MAX_PAYLOAD + 2);
    send_frame(DATA_W'($urandom_range(255)), len, DATA_W'($urandom_range(255)),
               DATA_W'($urandom_range(255)), corrupt);
  endtask

  // Let everything outstanding drain out of the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_head(input logic [DATA_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    head_cfg = v;
    heads_written++;
    cfg_wr_en <= 1'b0;
  endtask

  // Good frame with empty payload, reset head
  task automatic test_empty_payload();
    send_frame(8'ha5, MIN_BODY, 8'h11, 8'h22, 1'b0);
  endtask

  // Length too small / too large, with head found again during rescan
  task automatic test_bad_length();
    // address byte is the head: length byte becomes the new address
    send_byte(head_cfg);
    send_byte(head_cfg);
    send_byte(8'h01);
    continue_frame(8'd3, 8'h00, 8'hff, 1'b0);
    send_byte(head_cfg);
    send_byte(8'h10);
    send_byte(8'hff);
    send_byte(head_cfg);
    send_byte(8'h20);
    send_byte(DATA_W'(MAX_PAYLOAD + 3));
    // length byte is the head
    send_byte(head_cfg);
    send_byte(8'h30);
    send_byte(head_cfg);
    send_byte(8'h42);
    send_byte(8'h00);
  endtask

  task automatic test_bad_crc();
    send_frame(8'h5a, MIN_BODY, 8'h80, 8'h7f, 1'b1);
  endtask

  // Walk the head register through its extremes
  task automatic test_head_change();
    logic [DATA_W-1:0] heads [4];
    heads[0] = 8'h00;
    heads[1] = 8'hff;
    heads[2] = DATA_W'($urandom_range(255));
    heads[3] = HEAD_RESET;
    foreach (heads[i]) begin
      write_head(heads[i]);
      random_frame($urandom_range(9) == 0);
    end
    wait_idle();
  endtask

  // Receiver holds off while frames keep coming; input must back up
  task automatic test_backpressure();
    hold_req = 150;
    repeat (3) send_frame(DATA_W'($urandom_range(255)), 8'd10, DATA_W'($urandom_range(255)),
                          DATA_W'($urandom_range(255)), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    bit head_moved;
    start = items_sent;
    head_moved = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_idle = (items_sent - start > 60) && (items_sent - start < 160);
      if (!head_moved && items_sent - start > 100) begin
        write_head(DATA_W'($urandom_range(255)));
        head_moved = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 72) begin
        random_frame(1'b0);
      end else if (pick < 82) begin
        random_frame(1'b1);
      end else if (pick < 89) begin
        send_byte(head_cfg);
        send_byte(DATA_W'($urandom_range(255)));
        send_byte(DATA_W'($urandom_range(1) ? $urandom_range(1) :
                                              $urandom_range(MAX_PAYLOAD + 3, 255)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_byte(DATA_W'($urandom_range(255)));
      end else begin
        // truncated frame: next bytes get swallowed as its body
        send_byte(head_cfg);
        send_byte(DATA_W'($urandom_range(255)));
        send_byte(DATA_W'($urandom_range(5, MAX_PAYLOAD + 2)));
        repeat ($urandom_range(0, 2)) send_byte(DATA_W'($urandom_range(255)));
      end
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Receiver stall pattern, with long hold-offs on request
  initial begin : rx_stall_gen
    int held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        held = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (held - 1) @(posedge clk);
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 17);
      end
    end
  end

  // Compare each taken result item with the oldest queued one
  always @(posedge clk) begin : result_check
    frame_rec_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (frame_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_kind));
      end else begin
        want = frame_out_q.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("error_code", out_error_code, want.err);
        check_field("slave_addr", out_slave_addr, want.addr);
        check_field("frame_state", out_frame_state, want.state);
        check_field("function_code", out_function_code, want.func);
        check_field("payload_count", out_payload_count, want.count);
        check_field("data_byte", out_data_byte, want.data);
        check_field("last", out_last, want.last);
        case (want.kind)
          KIND_HDR:  n_hdr++;
          KIND_DATA: n_data++;
          default:   n_err++;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rs485_frame_parser_crc8: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_rx_byte  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_payload();
    test_bad_length();
    test_bad_crc();
    wait_idle();
    test_head_change();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d rx bytes across %0d head writes (0x00, 0xff, random, default)",
             items_sent, heads_written);
    $display("checked %0d headers, %0d payload bytes, %0d error reports",
             n_hdr, n_data, n_err);
    if (errors == 0 && frame_out_q.size() == 0) begin
      $display("tb_rs485_frame_parser_crc8: done, clean");
    end else begin
      $display("tb_rs485_frame_parser_crc8: done, errors");
    end
    $finish;
  end

endmodule
